// ===== rtl/mm4_pkg.sv =====
// Shared types for the 4x4 matrix multiplier.
`default_nettype none

package mm4_pkg;

    localparam int ELEM_W = 32;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int FRAC_W = 16;

    // One multiply-accumulate step issued by the sequencer.
    typedef struct packed {
        logic valid;
        logic first;     // first term of a dot product
        logic sum_done;  // final term of a dot product
        logic last;      // final term of the final product element
    } mm4_issue_t;

endpackage

`default_nettype wire

// ===== rtl/mm4_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/mm4_seq.sv =====
// Load counter and product-phase address sequencer.
`default_nettype none

module mm4_seq import mm4_pkg::*; #(
    parameter int DIM = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         slot_free,
    output logic                              wr_en,
    output logic [$clog2(DIM*DIM)-1:0]        wr_addr,
    output logic [$clog2(DIM*DIM)-1:0]        rd_addr_l,
    output logic [$clog2(DIM*DIM)-1:0]        rd_addr_r,
    output mm4_issue_t                        issue
);

    localparam int NELEM = DIM * DIM;
    localparam int AW    = $clog2(NELEM);
    localparam int CW    = $clog2(DIM);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_CALC = 1'b1;

    logic          state_reg, state_next;
    logic [AW-1:0] load_cnt_reg, load_cnt_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic [CW-1:0] i_reg, i_next;
    logic          accept;
    logic          go;
    logic          r_end, c_end, i_end;

    assign r_end = (r_reg == CW'(DIM - 1));
    assign c_end = (c_reg == CW'(DIM - 1));
    assign i_end = (i_reg == CW'(DIM - 1));

    assign in_ready = (state_reg == ST_LOAD);
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept;
    assign wr_addr  = load_cnt_reg;

    // a new dot product starts only when the output queue has room for it
    assign go = (state_reg == ST_CALC) && ((i_reg != '0) || slot_free);

    assign rd_addr_l = AW'(int'(r_reg) * DIM + int'(i_reg));
    assign rd_addr_r = AW'(int'(i_reg) * DIM + int'(c_reg));

    assign issue.valid    = go;
    assign issue.first    = (i_reg == '0);
    assign issue.sum_done = i_end;
    assign issue.last     = r_end && c_end && i_end;

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        i_next        = i_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (load_cnt_reg == AW'(NELEM - 1))
                    begin
                        load_cnt_next = '0;
                        state_next    = ST_CALC;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            ST_CALC:
            begin
                if (go)
                begin
                    i_next = i_end ? '0 : i_reg + 1'b1;
                    if (i_end)
                    begin
                        c_next = c_end ? '0 : c_reg + 1'b1;
                        if (c_end)
                        begin
                            r_next = r_end ? '0 : r_reg + 1'b1;
                            if (r_end)
                            begin
                                state_next = ST_LOAD;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            i_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            i_reg        <= i_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mm4_mac.sv =====
// Shared multiplier, accumulator and Q16.16 rounding/saturation.
`default_nettype none

module mm4_mac import mm4_pkg::*; #(
    parameter int DIM = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mm4_issue_t        issue,
    input  wire logic [ELEM_W-1:0] left_data,
    input  wire logic [ELEM_W-1:0] right_data,
    output logic                   push,
    output logic [ELEM_W-1:0]      result,
    output logic                   result_last
);

    localparam int ACC_W = PROD_W + $clog2(DIM);
    localparam int TOP_W = ACC_W - FRAC_W - ELEM_W + 1;

    mm4_issue_t               tag1_reg, tag2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_sum;
    logic [TOP_W-1:0]         top_bits;

    // tag1 lines up with RAM read data, tag2 with the product register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= issue;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(left_data) * $signed(right_data);
        if (tag2_reg.valid)
        begin
            acc_reg <= acc_sum;
        end
    end

    assign acc_sum = (tag2_reg.first ? ACC_W'(0) : acc_reg)
                   + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // floor shift by 16, then clamp when the upper bits are not a sign extension
    assign top_bits = acc_sum[ACC_W-1:FRAC_W+ELEM_W-1];

    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
        begin
            result = acc_sum[FRAC_W+ELEM_W-1:FRAC_W];
        end
        else if (acc_sum[ACC_W-1])
        begin
            result = {1'b1, {(ELEM_W - 1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(ELEM_W - 1){1'b1}}};
        end
    end

    assign push        = tag2_reg.valid && tag2_reg.sum_done;
    assign result_last = tag2_reg.last;

endmodule

`default_nettype wire

// ===== rtl/matrix_multiply_4x4_core.sv =====
// Top level of the matrix multiplier: element stores, sequencer, MAC and output queue.
`default_nettype none

// Loads DIM*DIM element pairs (left and right at the same row-major position),
// one per cycle, then computes left x right in signed Q16.16 on a single shared
// 32x32 multiplier, one multiply-accumulate per cycle while the output queue
// has room. The two element stores are one-read-port RAMs; the multiplier sets
// the pace. No input is taken during the product phase. Results leave
// row-major through a two-entry output queue, with last_element on the
// final one; a stalled output holds the next dot product from starting.
// Sums are floor-shifted by 16 and saturated to 32 bits. Stores are not cleared.
module matrix_multiply_4x4_core import mm4_pkg::*; #(
    parameter int DIM = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [ELEM_W-1:0] left_element,
    input  wire logic [ELEM_W-1:0] right_element,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ELEM_W-1:0]      product_element,
    output logic                   last_element
);

    localparam int NELEM = DIM * DIM;
    localparam int AW    = $clog2(NELEM);

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr_l, rd_addr_r;
    logic [ELEM_W-1:0] left_data, right_data;
    mm4_issue_t        issue;
    logic              slot_free;
    logic              push;
    logic [ELEM_W-1:0] result;
    logic              result_last;
    logic              pop;

    logic [ELEM_W-1:0] fifo_data_reg [2];
    logic              fifo_last_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        fifo_count_reg, fifo_count_next;
    logic [1:0]        inflight_reg, inflight_next;
    logic [2:0]        occupancy;

    mm4_seq #(.DIM(DIM)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .slot_free (slot_free),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_addr_l (rd_addr_l),
        .rd_addr_r (rd_addr_r),
        .issue     (issue)
    );

    mm4_ram #(.WIDTH(ELEM_W), .DEPTH(NELEM)) u_left_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (left_element),
        .rd_addr (rd_addr_l),
        .rd_data (left_data)
    );

    mm4_ram #(.WIDTH(ELEM_W), .DEPTH(NELEM)) u_right_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (right_element),
        .rd_addr (rd_addr_r),
        .rd_data (right_data)
    );

    mm4_mac #(.DIM(DIM)) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .left_data   (left_data),
        .right_data  (right_data),
        .push        (push),
        .result      (result),
        .result_last (result_last)
    );

    // credit check: dot products in flight plus queued results fit the queue
    assign occupancy = 3'(inflight_reg) + 3'(fifo_count_reg);
    assign slot_free = (occupancy < 3'd2);

    assign pop             = out_valid && out_ready;
    assign out_valid       = (fifo_count_reg != 2'd0);
    assign product_element = fifo_data_reg[rd_ptr_reg];
    assign last_element    = fifo_last_reg[rd_ptr_reg];

    assign fifo_count_next = fifo_count_reg + 2'(push) - 2'(pop);
    assign inflight_next   = inflight_reg + 2'(issue.valid && issue.first) - 2'(push);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_data_reg[wr_ptr_reg] <= result;
            fifo_last_reg[wr_ptr_reg] <= result_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            fifo_count_reg <= 2'd0;
            inflight_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fifo_count_reg <= fifo_count_next;
            inflight_reg   <= inflight_next;
        end
    end

    a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= 3'd2)
        else $error("output queue credit overrun");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_count_reg != 2'd2))
        else $error("result pushed into a full output queue");

    a_no_load_during_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !issue.valid)
        else $error("store read issued while loading");

    a_last_closes_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (push && result_last) |=> (inflight_reg == 2'd0))
        else $error("dot product still in flight after final element");

endmodule

`default_nettype wire
